/* sv/sghp_pkg.sv */
package sghp_pkg;

    localparam int TAG_BITS  = 8;
    localparam int PROB_BITS = 16;
    localparam int RUN_BITS  = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CHUNK = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic REQ_FRAME     = 1'b0;
    localparam logic REQ_FORCE_END = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ACT_THRESH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEACT_THRESH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_WT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEECH_NEED  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SILENCE_NEED = 3'd4;

    localparam logic [PROB_BITS-1:0] ACT_THRESH_RST   = 16'd32768;
    localparam logic [PROB_BITS-1:0] DEACT_THRESH_RST = 16'd22938;
    localparam logic [PROB_BITS-1:0] SMOOTH_WT_RST    = 16'd22938;
    localparam logic [RUN_BITS-1:0]  SPEECH_NEED_RST  = 8'd8;
    localparam logic [RUN_BITS-1:0]  SILENCE_NEED_RST = 8'd19;

    typedef struct packed {
        logic                 req_type;
        logic [PROB_BITS-1:0] frame_prob;
        logic [TAG_BITS-1:0]  frame_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]           event_code;
        logic [TAG_BITS-1:0]  chunk_tag;
        logic [PROB_BITS-1:0] prob_out;
        logic                 last;
    } evt_t;

    typedef struct packed {
        logic [PROB_BITS-1:0] act_thresh;
        logic [PROB_BITS-1:0] deact_thresh;
        logic [PROB_BITS-1:0] smooth_wt;
        logic [RUN_BITS-1:0]  speech_need;
        logic [RUN_BITS-1:0]  silence_need;
    } cfg_t;

endpackage

/* sv/sghp_ring.sv */
module sghp_ring
    import sghp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [TAG_BITS-1:0] wdata,
    input  logic [AW-1:0]       raddr,
    output logic [TAG_BITS-1:0] rdata
);

    logic [TAG_BITS-1:0] mem [DEPTH];
    logic [TAG_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sghp_obuf.sv */
module sghp_obuf
    import sghp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  evt_t push_data,
    output logic push_ready,
    output logic evt_valid,
    input  logic evt_stall,
    output evt_t evt_data
);

    logic evt_valid_reg;
    evt_t evt_data_reg;

    assign push_ready = !evt_valid_reg || !evt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (push_valid && push_ready)
        begin
            evt_valid_reg <= 1'b1;
        end
        else if (!evt_stall)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            evt_data_reg <= push_data;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_data_reg;

endmodule

/* sv/sghp_ctrl.sv */
module sghp_ctrl
    import sghp_pkg::*;
#(
    parameter int PREFIX_DEPTH = 16,
    parameter int HEAD_W       = 4,
    parameter int FILL_W       = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req_data,
    output logic                push_valid,
    output evt_t                push_data,
    input  logic                push_ready,
    output logic                ring_we,
    output logic [HEAD_W-1:0]   ring_waddr,
    output logic [TAG_BITS-1:0] ring_wdata,
    output logic [HEAD_W-1:0]   ring_raddr,
    input  logic [TAG_BITS-1:0] ring_rdata
);

    localparam int IW = FILL_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DECIDE,
        S_START,
        S_REPLAY,
        S_REPLAY_RD,
        S_CHUNK,
        S_END
    } state_t;

    state_t               state_reg;
    logic                 speaking_reg;
    logic [PROB_BITS-1:0] smoothed_reg;
    logic                 sm_valid_reg;
    logic [RUN_BITS-1:0]  speech_run_reg;
    logic [RUN_BITS-1:0]  silence_run_reg;
    logic [HEAD_W-1:0]    head_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [PROB_BITS-1:0] raw_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic signed [33:0]   prod_reg;
    logic [HEAD_W-1:0]    rd_idx_reg;
    logic [FILL_W-1:0]    remain_reg;
    logic                 end_pend_reg;
    logic [PROB_BITS-1:0] end_prob_reg;

    logic signed [16:0]   diff;
    logic signed [16:0]   weight_s;
    logic signed [33:0]   prod;
    logic signed [34:0]   sum;
    logic                 is_speech;
    logic [RUN_BITS-1:0]  speech_inc;
    logic [RUN_BITS-1:0]  silence_inc;
    logic [HEAD_W-1:0]    head_next;
    logic [FILL_W-1:0]    fill_next;
    logic [IW-1:0]        head_x;
    logic [IW-1:0]        fill_x;
    logic [IW-1:0]        start_x;
    logic [HEAD_W-1:0]    rd_idx_next;

    assign diff     = $signed({1'b0, smoothed_reg}) - $signed({1'b0, raw_reg});
    assign weight_s = $signed({1'b0, cfg.smooth_wt});
    assign prod     = diff * weight_s;
    assign sum      = $signed({3'b000, raw_reg, 16'h0000}) + 35'(prod_reg) + 35'sd32768;

    assign is_speech = (smoothed_reg >= cfg.act_thresh) ||
                       (speaking_reg && (smoothed_reg > cfg.deact_thresh));

    assign speech_inc  = (speech_run_reg == '1) ? speech_run_reg : speech_run_reg + 1'b1;
    assign silence_inc = (silence_run_reg == '1) ? silence_run_reg : silence_run_reg + 1'b1;

    assign head_next = (head_reg == HEAD_W'(PREFIX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign fill_next = (fill_reg == FILL_W'(PREFIX_DEPTH)) ? fill_reg : fill_reg + 1'b1;

    assign head_x  = IW'(head_next);
    assign fill_x  = IW'(fill_next);
    assign start_x = (head_x >= fill_x) ? head_x - fill_x
                                        : head_x + IW'(PREFIX_DEPTH) - fill_x;

    assign rd_idx_next = (rd_idx_reg == HEAD_W'(PREFIX_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    assign req_stall  = (state_reg != S_IDLE);
    assign ring_we    = (state_reg == S_DECIDE) && !speaking_reg;
    assign ring_waddr = head_reg;
    assign ring_wdata = tag_reg;
    assign ring_raddr = rd_idx_reg;

    always_comb
    begin
        push_valid = 1'b0;
        push_data  = '0;
        unique case (state_reg)
            S_START:
            begin
                push_valid           = 1'b1;
                push_data.event_code = EV_START;
                push_data.prob_out   = smoothed_reg;
            end
            S_REPLAY:
            begin
                push_valid           = 1'b1;
                push_data.event_code = EV_CHUNK;
                push_data.chunk_tag  = ring_rdata;
                push_data.last       = (remain_reg == FILL_W'(1));
            end
            S_CHUNK:
            begin
                push_valid           = 1'b1;
                push_data.event_code = EV_CHUNK;
                push_data.chunk_tag  = tag_reg;
                push_data.prob_out   = smoothed_reg;
                push_data.last       = !end_pend_reg;
            end
            S_END:
            begin
                push_valid           = 1'b1;
                push_data.event_code = EV_END;
                push_data.prob_out   = end_prob_reg;
                push_data.last       = 1'b1;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            speaking_reg    <= 1'b0;
            smoothed_reg    <= '0;
            sm_valid_reg    <= 1'b0;
            speech_run_reg  <= '0;
            silence_run_reg <= '0;
            head_reg        <= '0;
            fill_reg        <= '0;
            raw_reg         <= '0;
            tag_reg         <= '0;
            prod_reg        <= '0;
            rd_idx_reg      <= '0;
            remain_reg      <= '0;
            end_pend_reg    <= 1'b0;
            end_prob_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_data.req_type == REQ_FORCE_END)
                        begin
                            if (speaking_reg)
                            begin
                                speaking_reg    <= 1'b0;
                                speech_run_reg  <= '0;
                                silence_run_reg <= '0;
                                end_prob_reg    <= '0;
                                state_reg       <= S_END;
                            end
                        end
                        else
                        begin
                            raw_reg   <= req_data.frame_prob;
                            tag_reg   <= req_data.frame_tag;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    smoothed_reg <= sm_valid_reg ? sum[31:16] : raw_reg;
                    sm_valid_reg <= 1'b1;
                    state_reg    <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (!speaking_reg)
                    begin
                        head_reg  <= head_next;
                        fill_reg  <= fill_next;
                        state_reg <= S_IDLE;
                        if (is_speech)
                        begin
                            silence_run_reg <= '0;
                            speech_run_reg  <= speech_inc;
                            if (speech_inc >= cfg.speech_need)
                            begin
                                speaking_reg <= 1'b1;
                                rd_idx_reg   <= start_x[HEAD_W-1:0];
                                remain_reg   <= fill_next;
                                head_reg     <= '0;
                                fill_reg     <= '0;
                                state_reg    <= S_START;
                            end
                        end
                        else
                        begin
                            speech_run_reg <= '0;
                        end
                    end
                    else
                    begin
                        end_pend_reg <= 1'b0;
                        state_reg    <= S_CHUNK;
                        if (is_speech)
                        begin
                            silence_run_reg <= '0;
                            speech_run_reg  <= speech_inc;
                        end
                        else
                        begin
                            speech_run_reg <= '0;
                            if (silence_inc >= cfg.silence_need)
                            begin
                                speaking_reg    <= 1'b0;
                                silence_run_reg <= '0;
                                end_pend_reg    <= 1'b1;
                                end_prob_reg    <= smoothed_reg;
                            end
                            else
                            begin
                                silence_run_reg <= silence_inc;
                            end
                        end
                    end
                end
                S_START:
                begin
                    if (push_ready)
                    begin
                        state_reg <= S_REPLAY;
                    end
                end
                S_REPLAY:
                begin
                    if (push_ready)
                    begin
                        if (remain_reg == FILL_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            remain_reg <= remain_reg - 1'b1;
                            rd_idx_reg <= rd_idx_next;
                            state_reg  <= S_REPLAY_RD;
                        end
                    end
                end
                S_REPLAY_RD:
                begin
                    state_reg <= S_REPLAY;
                end
                S_CHUNK:
                begin
                    if (push_ready)
                    begin
                        state_reg <= end_pend_reg ? S_END : S_IDLE;
                    end
                end
                S_END:
                begin
                    if (push_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/speech_gate_hysteresis_prefix_top.sv */
// Speech gate with hysteresis, hangover and prefix padding.
// Request channel (req_valid / req_stall / req_data): one transfer per audio
// frame (tag and raw probability) or a force-end request.
// Event channel (evt_valid / evt_stall / evt_data): start, chunk and end
// events; last marks the final event caused by one request.
// Configuration: cfg_write_en, cfg_index, cfg_data; write only while idle.
// Sequence: a frame transfer is followed by a multiply, an add and a decision
// state; its first event is then registered from the start or chunk state.
// A silent frame without speech start gives no event; a speaking frame gives
// a chunk event, then an end event if it ends speech. A speech start with N
// buffered tags gives a start event and N replayed chunks: the tag ring is a
// one-port-read memory with a registered read, so each replayed chunk after
// the first waits on a read state. A force end emits an end event if speaking.
// The event register holds one event; while the receiver stalls, the gate
// waits on its next event and req_stall stays high.
// Reset clears the state, the run counters, the ring fill and head, and
// loads the register defaults; ring contents are not cleared.
module speech_gate_hysteresis_prefix_top
    import sghp_pkg::*;
#(
    parameter int PREFIX_DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  req_t                      req_data,
    output logic                      evt_valid,
    input  logic                      evt_stall,
    output evt_t                      evt_data,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int HEAD_W = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
    localparam int FILL_W = $clog2(PREFIX_DEPTH + 1);

    cfg_t                cfg_reg;
    logic                push_valid;
    evt_t                push_data;
    logic                push_ready;
    logic                ring_we;
    logic [HEAD_W-1:0]   ring_waddr;
    logic [TAG_BITS-1:0] ring_wdata;
    logic [HEAD_W-1:0]   ring_raddr;
    logic [TAG_BITS-1:0] ring_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_thresh   <= ACT_THRESH_RST;
            cfg_reg.deact_thresh <= DEACT_THRESH_RST;
            cfg_reg.smooth_wt    <= SMOOTH_WT_RST;
            cfg_reg.speech_need  <= SPEECH_NEED_RST;
            cfg_reg.silence_need <= SILENCE_NEED_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ACT_THRESH:   cfg_reg.act_thresh   <= cfg_data;
                REG_DEACT_THRESH: cfg_reg.deact_thresh <= cfg_data;
                REG_SMOOTH_WT:    cfg_reg.smooth_wt    <= cfg_data;
                REG_SPEECH_NEED:  cfg_reg.speech_need  <= cfg_data[RUN_BITS-1:0];
                REG_SILENCE_NEED: cfg_reg.silence_need <= cfg_data[RUN_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    sghp_ctrl #(
        .PREFIX_DEPTH (PREFIX_DEPTH),
        .HEAD_W       (HEAD_W),
        .FILL_W       (FILL_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .ring_raddr (ring_raddr),
        .ring_rdata (ring_rdata)
    );

    sghp_ring #(
        .DEPTH (PREFIX_DEPTH),
        .AW    (HEAD_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    sghp_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data)
    );

endmodule

/* sv/sghp_checker.sv */
module sghp_checker
    import sghp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic evt_valid,
    input logic evt_stall,
    input evt_t evt_data
);

    // hold a stalled event
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt_data))
        else $error("stalled event changed or dropped");

    // block busy after a frame transfer
    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.req_type == REQ_FRAME) |=> req_stall)
        else $error("frame transfer not followed by busy");

    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_data.event_code == EV_START) |-> !evt_data.last)
        else $error("start event marked last");

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_data.event_code != EV_CHUNK) |-> (evt_data.chunk_tag == '0))
        else $error("non-chunk event carries a tag");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_data.event_code == EV_END) |-> evt_data.last)
        else $error("end event not marked last");

endmodule

bind speech_gate_hysteresis_prefix_top sghp_checker u_sghp_checker (.*);
